@@ rtl/core/coincidence_window_event_builder_core_macros.svh @@
// Assertion macros for the coincidence window event builder.
// Included by the top level; no other dependencies.
`ifndef COINCIDENCE_WINDOW_EVENT_BUILDER_CORE_MACROS_SVH
`define COINCIDENCE_WINDOW_EVENT_BUILDER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge out of reset.
`define CWEB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every clock edge out of reset.
`define CWEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CWEB_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define CWEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/cweb_pkg.sv @@
// Shared widths, codes and types of the coincidence window event builder.
// No dependencies; every other file of the block but the macro header imports it.
package cweb_pkg;

  localparam int CH_W         = 3;
  localparam int Q_W          = 16;
  localparam int TS_W         = 47;
  localparam int ST_W         = TS_W + 1;
  localparam int WIN_W        = 32;
  localparam int EVT_W        = 32;
  localparam int MAX_SLOTS    = 8;
  localparam int CHANNELS_DEF = 8;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(200);

  // Operation codes of an input beat
  localparam logic OP_HIT   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0]      channel;
    logic [Q_W-1:0]       charge_short;
    logic [Q_W-1:0]       charge_long;
    logic [TS_W-1:0]      timestamp;
    logic signed [Q_W-1:0] fine_time;
  } hit_t;

  typedef struct packed {
    logic [CH_W-1:0]       slot_channel;
    logic                  present;
    logic [Q_W-1:0]        charge_short;
    logic [Q_W-1:0]        charge_long;
    logic [TS_W-1:0]       timestamp;
    logic signed [Q_W-1:0] fine_time;
    logic [EVT_W-1:0]      event_number;
    logic                  last;
  } rec_t;

  // Controller to datapath
  typedef struct packed {
    logic open_in;    // clear slots, open event with the input hit
    logic store_in;   // store the input hit in its slot
    logic save_pend;  // hold the closing hit until the old event is out
    logic emit_step;  // load one slot record into the output register
    logic finish;     // event emitted: count it, clear slots
    logic reopen;     // with finish: open the next event from the held hit
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_flush;
    logic ch_ok;
    logic event_open;
    logic in_window;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/cweb_stream_if.sv @@
// Valid/ready stream interfaces for hit beats and slot record beats.
// Depends on cweb_pkg.
interface cweb_hit_if import cweb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [CH_W-1:0]       channel;
  logic [Q_W-1:0]        charge_short;
  logic [Q_W-1:0]        charge_long;
  logic [TS_W-1:0]       timestamp;
  logic signed [Q_W-1:0] fine_time;

  modport source (
    output valid, operation, channel, charge_short, charge_long, timestamp, fine_time,
    input  ready
  );
  modport sink (
    input  valid, operation, channel, charge_short, charge_long, timestamp, fine_time,
    output ready
  );
endinterface

interface cweb_rec_if import cweb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_W-1:0]       slot_channel;
  logic                  present;
  logic [Q_W-1:0]        out_charge_short;
  logic [Q_W-1:0]        out_charge_long;
  logic [TS_W-1:0]       out_timestamp;
  logic signed [Q_W-1:0] out_fine_time;
  logic [EVT_W-1:0]      event_number;
  logic                  last;

  modport source (
    output valid, slot_channel, present, out_charge_short, out_charge_long,
           out_timestamp, out_fine_time, event_number, last,
    input  ready
  );
  modport sink (
    input  valid, slot_channel, present, out_charge_short, out_charge_long,
           out_timestamp, out_fine_time, event_number, last,
    output ready
  );
endinterface

@@ rtl/core/coincidence_window_event_builder_core.sv @@
// Channel   Dir  Beat                                    Handshake
// hits      in   operation, channel, charges, time, fine valid/ready
// records   out  one slot record, present, event, last   valid/ready
// window_*  in   coincidence window, 32 bits             write enable, no read-back
//
// A hit that opens an event or falls inside the window is stored in its slot when accepted.
// A closing hit, or a flush while an event is open, emits the event: the SLOTS = min(CHANNELS, 8)
// slot registers are read one slot per cycle into the output register unless records stalls.
// A stalled records channel holds the slot counter; hits wait until the last slot is loaded.
// Reset is synchronous; window resets to 200, no event open, no clearing pass.
//
// Top level of the coincidence window event builder.
// Depends on cweb_pkg, cweb_stream_if, cweb_ctrl, cweb_dp and the macro header.
`include "coincidence_window_event_builder_core_macros.svh"

module coincidence_window_event_builder_core import cweb_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             window_we,
  input  logic [WIN_W-1:0] window_wdata,
  cweb_hit_if.sink         hits,
  cweb_rec_if.source       records
);

  localparam int SLOTS = (CHANNELS < MAX_SLOTS) ? CHANNELS : MAX_SLOTS;

  hit_t    hit;
  cmd_t    cmd;
  status_t stat;
  rec_t    rec;
  logic    rec_valid;

  // Pack the hit beat
  assign hit.channel      = hits.channel;
  assign hit.charge_short = hits.charge_short;
  assign hit.charge_long  = hits.charge_long;
  assign hit.timestamp    = hits.timestamp;
  assign hit.fine_time    = hits.fine_time;

  cweb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (hits.valid),
    .in_ready (hits.ready),
    .status   (stat),
    .cmd      (cmd)
  );

  cweb_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .window_we    (window_we),
    .window_wdata (window_wdata),
    .operation    (hits.operation),
    .hit          (hit),
    .cmd          (cmd),
    .status       (stat),
    .rec_valid    (rec_valid),
    .rec_ready    (records.ready),
    .rec          (rec)
  );

  // Unpack the record beat
  assign records.valid            = rec_valid;
  assign records.slot_channel     = rec.slot_channel;
  assign records.present          = rec.present;
  assign records.out_charge_short = rec.charge_short;
  assign records.out_charge_long  = rec.charge_long;
  assign records.out_timestamp    = rec.timestamp;
  assign records.out_fine_time    = rec.fine_time;
  assign records.event_number     = rec.event_number;
  assign records.last             = rec.last;

  // Checks
  `CWEB_ASSERT_NEXT(a_back_to_idle, clk, rst, cmd.emit_step && stat.idx_last, hits.ready, "no return to idle after last slot")
  `CWEB_ASSERT_NOW(a_last_slot, clk, rst, records.valid && records.last, records.slot_channel == CH_W'(SLOTS - 1), "last marker on wrong slot")
  `CWEB_ASSERT_NOW(a_no_emit_idle, clk, rst, hits.ready, !cmd.emit_step, "slot emitted while taking hits")
  `CWEB_ASSERT_NEXT(a_empty_flush, clk, rst, hits.valid && hits.ready && hits.operation == OP_FLUSH && !stat.event_open, hits.ready, "flush of no event started emission")

endmodule

@@ rtl/core/cweb_ctrl.sv @@
// Controller of the event builder: accepts hit beats and sequences emission.
// Depends on cweb_pkg; drives cweb_dp through cmd_t, reads status_t.
module cweb_ctrl import cweb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic reopen;
  logic reopen_next;

  // Decide the work for this cycle
  always_comb begin
    cmd         = '0;
    state_next  = state;
    reopen_next = reopen;
    in_ready    = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.is_flush) begin
            if (status.event_open) begin
              reopen_next = 1'b0;
              state_next  = ST_EMIT;
            end
          end else if (status.ch_ok) begin
            if (!status.event_open) begin
              cmd.open_in = 1'b1;
            end else if (status.in_window) begin
              cmd.store_in = 1'b1;
            end else begin
              cmd.save_pend = 1'b1;
              reopen_next   = 1'b1;
              state_next    = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        // Advance one slot whenever the output register can take it
        if (status.out_free) begin
          cmd.emit_step = 1'b1;
          if (status.idx_last) begin
            cmd.finish = 1'b1;
            cmd.reopen = reopen;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      reopen <= 1'b0;
    end else begin
      state  <= state_next;
      reopen <= reopen_next;
    end
  end

endmodule

@@ rtl/core/cweb_dp.sv @@
// Datapath of the event builder: window register, slot store, window test,
// held closing hit, slot counter and output register. Depends on cweb_pkg.
module cweb_dp import cweb_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             window_we,
  input  logic [WIN_W-1:0] window_wdata,
  input  logic             operation,
  input  hit_t             hit,
  input  cmd_t             cmd,
  output status_t          status,
  output logic             rec_valid,
  input  logic             rec_ready,
  output rec_t             rec
);

  localparam int SLOTS  = (CHANNELS < MAX_SLOTS) ? CHANNELS : MAX_SLOTS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic [WIN_W-1:0]      window;
  logic                  event_open;
  logic [ST_W-1:0]       start_time;
  logic [EVT_W-1:0]      events_done;
  logic [SLOTS-1:0]      present;
  logic [SLOTS-1:0]      present_next;
  logic [Q_W-1:0]        slot_short [SLOTS];
  logic [Q_W-1:0]        slot_long  [SLOTS];
  logic [TS_W-1:0]       slot_time  [SLOTS];
  logic signed [Q_W-1:0] slot_fine  [SLOTS];
  hit_t                  pend;
  logic [SLOT_W-1:0]     idx;

  hit_t              wr_hit;
  logic              wr_en;
  logic              open_any;
  logic [SLOT_W-1:0] wr_slot;
  logic [ST_W-1:0]   now;
  logic [ST_W-1:0]   dist_fwd;
  logic [ST_W-1:0]   dist_bwd;
  logic [ST_W-1:0]   span;
  logic              slot_p;

  // Window test on doubled timestamps, distance without wrap
  assign now      = {hit.timestamp, 1'b0};
  assign dist_fwd = now - start_time;
  assign dist_bwd = start_time - now;
  assign span     = (now >= start_time) ? dist_fwd : dist_bwd;

  assign status.is_flush   = (operation == OP_FLUSH);
  assign status.ch_ok      = ({1'b0, hit.channel} < (CH_W + 1)'(SLOTS));
  assign status.event_open = event_open;
  assign status.in_window  = (span <= ST_W'(window));
  assign status.idx_last   = (idx == LAST_SLOT);
  assign status.out_free   = !rec_valid || rec_ready;

  // Slot write source: the input hit, or the held hit when reopening
  assign open_any = cmd.open_in || (cmd.finish && cmd.reopen);
  assign wr_hit   = (cmd.finish && cmd.reopen) ? pend : hit;
  assign wr_en    = cmd.store_in || open_any;
  assign wr_slot  = wr_hit.channel[SLOT_W-1:0];

  always_comb begin
    present_next = present;
    if (cmd.open_in || cmd.finish) begin
      present_next = '0;
    end
    if (wr_en) begin
      present_next[wr_slot] = 1'b1;
    end
  end

  // Control state: window, event flag, present bits, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= WINDOW_RESET;
      event_open  <= 1'b0;
      start_time  <= '0;
      events_done <= '0;
      present     <= '0;
      idx         <= '0;
      rec_valid   <= 1'b0;
    end else begin
      if (window_we) begin
        window <= window_wdata;
      end
      if (cmd.open_in) begin
        event_open <= 1'b1;
      end else if (cmd.finish) begin
        event_open <= cmd.reopen;
      end
      if (open_any) begin
        start_time <= {wr_hit.timestamp, 1'b0};
      end
      if (cmd.finish) begin
        events_done <= events_done + EVT_W'(1);
      end
      present <= present_next;
      if (cmd.emit_step) begin
        idx <= (idx == LAST_SLOT) ? '0 : idx + SLOT_W'(1);
      end
      if (cmd.emit_step) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  // Slot payload store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_short[wr_slot] <= wr_hit.charge_short;
      slot_long[wr_slot]  <= wr_hit.charge_long;
      slot_time[wr_slot]  <= wr_hit.timestamp;
      slot_fine[wr_slot]  <= wr_hit.fine_time;
    end
  end

  // Hold the closing hit while the old event drains
  always_ff @(posedge clk) begin
    if (cmd.save_pend) begin
      pend <= hit;
    end
  end

  // Output register: one slot record per step, zeroed where absent
  assign slot_p = present[idx];

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      rec.slot_channel <= CH_W'(idx);
      rec.present      <= slot_p;
      rec.charge_short <= slot_p ? slot_short[idx] : '0;
      rec.charge_long  <= slot_p ? slot_long[idx] : '0;
      rec.timestamp    <= slot_p ? slot_time[idx] : '0;
      rec.fine_time    <= slot_p ? slot_fine[idx] : '0;
      rec.event_number <= events_done;
      rec.last         <= (idx == LAST_SLOT);
    end
  end

endmodule

@@ verif/tb_coincidence_window_event_builder_core.sv @@
// Self-checking testbench of the coincidence window event builder core.
// Uses cweb_pkg, the cweb_hit_if / cweb_rec_if stream interfaces and the core.
// Drives hits and flushes, predicts the slot records and checks them in order.
module tb_coincidence_window_event_builder_core import cweb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT = (CHANNELS_DEF < MAX_SLOTS) ? CHANNELS_DEF : MAX_SLOTS;
  localparam int DRAIN_CYCLES = SLOT_COUNT + 4;
  localparam int HOLD_OFF_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic window_we;
  logic [WIN_W-1:0] window_wdata;

  cweb_hit_if hit_bus ();
  cweb_rec_if rec_bus ();

  coincidence_window_event_builder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .window_we    (window_we),
    .window_wdata (window_wdata),
    .hits         (hit_bus),
    .records      (rec_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shared run state
  bit idle_enabled = 1'b1;
  int unsigned rx_hold_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned beats_sent = 0;
  int unsigned records_seen = 0;
  int unsigned events_seen = 0;
  rec_t expected_records[$];

  // Event builder state as predicted from accepted beats
  logic [WIN_W-1:0] bld_window = WINDOW_RESET;
  logic             bld_open = 1'b0;
  logic [ST_W-1:0]  bld_start = '0;
  logic [EVT_W-1:0] bld_events = '0;
  logic             bld_present [SLOT_COUNT];
  logic [Q_W-1:0]   bld_short [SLOT_COUNT];
  logic [Q_W-1:0]   bld_long [SLOT_COUNT];
  logic [TS_W-1:0]  bld_time [SLOT_COUNT];
  logic [Q_W-1:0]   bld_fine [SLOT_COUNT];

  function automatic void bld_clear_slots();
    for (int k = 0; k < SLOT_COUNT; k++) begin
      bld_present[k] = 1'b0;
      bld_short[k] = '0;
      bld_long[k] = '0;
      bld_time[k] = '0;
      bld_fine[k] = '0;
    end
  endfunction

  function automatic void bld_store(input hit_t h);
    bld_present[h.channel] = 1'b1;
    bld_short[h.channel] = h.charge_short;
    bld_long[h.channel] = h.charge_long;
    bld_time[h.channel] = h.timestamp;
    bld_fine[h.channel] = h.fine_time;
  endfunction

  function automatic void bld_open_event(input hit_t h);
    bld_clear_slots();
    bld_start = {h.timestamp, 1'b0};
    bld_store(h);
    bld_open = 1'b1;
  endfunction

  // Queue one record per slot for the open event, then count it
  function automatic void bld_emit_event();
    rec_t rec;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      rec.slot_channel = CH_W'(k);
      rec.present = bld_present[k];
      rec.charge_short = bld_present[k] ? bld_short[k] : '0;
      rec.charge_long = bld_present[k] ? bld_long[k] : '0;
      rec.timestamp = bld_present[k] ? bld_time[k] : '0;
      rec.fine_time = bld_present[k] ? bld_fine[k] : '0;
      rec.event_number = bld_events;
      rec.last = (k == SLOT_COUNT - 1);
      expected_records.push_back(rec);
    end
    bld_events = bld_events + EVT_W'(1);
  endfunction

  // Advance the predicted state by one accepted beat
  function automatic void predict_event_records(input logic op, input hit_t h);
    logic [ST_W-1:0] now_t;
    logic [ST_W-1:0] span;
    if (op == OP_FLUSH) begin
      if (bld_open) begin
        bld_emit_event();
        bld_open = 1'b0;
        bld_clear_slots();
      end
    end else if (int'(h.channel) < SLOT_COUNT) begin
      if (!bld_open) begin
        bld_open_event(h);
      end else begin
        now_t = {h.timestamp, 1'b0};
        span = (now_t >= bld_start) ? now_t - bld_start : bld_start - now_t;
        if (span <= ST_W'(bld_window)) begin
          bld_store(h);
        end else begin
          bld_emit_event();
          bld_open_event(h);
        end
      end
    end
  endfunction

  function automatic logic [TS_W-1:0] rand_ts();
    return TS_W'({$urandom, $urandom});
  endfunction

  function automatic hit_t make_hit(input int ch, input logic [Q_W-1:0] qs,
                                    input logic [Q_W-1:0] ql, input logic [TS_W-1:0] ts,
                                    input logic [Q_W-1:0] ft);
    hit_t h;
    h.channel = CH_W'(ch);
    h.charge_short = qs;
    h.charge_long = ql;
    h.timestamp = ts;
    h.fine_time = ft;
    return h;
  endfunction

  function automatic hit_t rand_hit(input logic [TS_W-1:0] ts);
    return make_hit($urandom_range(0, 7), Q_W'($urandom), Q_W'($urandom), ts,
                    Q_W'($urandom));
  endfunction

  // Offer one beat, hold it until accepted, then predict its records
  task automatic send_beat(input logic op, input hit_t h);
    int gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      hit_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hit_bus.valid <= 1'b1;
    hit_bus.operation <= op;
    hit_bus.channel <= h.channel;
    hit_bus.charge_short <= h.charge_short;
    hit_bus.charge_long <= h.charge_long;
    hit_bus.timestamp <= h.timestamp;
    hit_bus.fine_time <= h.fine_time;
    do @(posedge clk); while (!hit_bus.ready);
    predict_event_records(op, h);
    beats_sent++;
  endtask

  // Drop valid, wait for every expected record, then let the core settle
  task automatic wait_idle();
    hit_bus.valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    window_we <= 1'b1;
    window_wdata <= value;
    @(posedge clk);
    bld_window = value;
    window_we <= 1'b0;
  endtask

  // Default window: both window edges, early hit, overwrite, flush on empty
  task automatic test_window_edges();
    send_beat(OP_HIT, make_hit(0, 16'h1111, 16'h2222, 47'd1000, 16'h0001));
    send_beat(OP_HIT, make_hit(1, 16'h3333, 16'h4444, 47'd1100, 16'hFFFF));
    send_beat(OP_HIT, make_hit(2, 16'h5555, 16'h6666, 47'd900, 16'h1234));
    send_beat(OP_HIT, make_hit(1, 16'h7777, 16'h8888, 47'd1050, 16'h8001));
    send_beat(OP_HIT, make_hit(5, 16'h9999, 16'hAAAA, 47'd1101, 16'h7FFE));
    send_beat(OP_FLUSH, rand_hit(rand_ts()));
    send_beat(OP_FLUSH, rand_hit(rand_ts()));
    wait_idle();
  endtask

  // Widest window with field extremes on both ends
  task automatic test_field_extremes();
    write_window('1);
    send_beat(OP_HIT, make_hit(7, 16'hFFFF, 16'hFFFF, '1, 16'h8000));
    send_beat(OP_HIT, make_hit(0, 16'h0000, 16'h0000, '0, 16'h7FFF));
    send_beat(OP_HIT, make_hit(3, 16'hA5A5, 16'h5A5A, 47'h0000_7FFF_FFFF, 16'h0000));
    send_beat(OP_HIT, make_hit(4, 16'h0F0F, 16'hF0F0, 47'h0000_8000_0000, 16'hFFFF));
    send_beat(OP_FLUSH, rand_hit(rand_ts()));
    wait_idle();
  endtask

  // Zero window: only an identical timestamp joins the event
  task automatic test_zero_window();
    write_window('0);
    send_beat(OP_HIT, make_hit(4, 16'h0001, 16'h0002, 47'd5, 16'h0003));
    send_beat(OP_HIT, make_hit(5, 16'h0004, 16'h0005, 47'd5, 16'h0006));
    send_beat(OP_HIT, make_hit(6, 16'h0007, 16'h0008, 47'd6, 16'h0009));
    send_beat(OP_HIT, make_hit(6, 16'h000A, 16'h000B, 47'd4, 16'h000C));
    send_beat(OP_FLUSH, rand_hit(rand_ts()));
    wait_idle();
  endtask

  // Every hit after the first closes an event while the receiver holds off
  task automatic test_backpressure();
    logic [TS_W-1:0] ts;
    write_window(WINDOW_RESET);
    ts = rand_ts() >> 8;
    rx_hold_cycles = HOLD_OFF_CYCLES;
    for (int i = 0; i < 15; i++) begin
      send_beat(OP_HIT, rand_hit(ts));
      ts = ts + TS_W'(101 + $urandom_range(0, 400));
    end
    send_beat(OP_FLUSH, rand_hit(rand_ts()));
    wait_idle();
  endtask

  // Mostly time-ordered events with random content, plus jumps and flushes
  task automatic test_random_stream(input int count, input logic [WIN_W-1:0] win);
    logic [TS_W-1:0] ev_ts;
    logic [TS_W-1:0] ts;
    logic [WIN_W-1:0] half;
    int unsigned pick;
    write_window(win);
    half = win >> 1;
    ev_ts = rand_ts() >> $urandom_range(0, TS_W - 1);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_beat(OP_FLUSH, rand_hit(rand_ts()));
      end else if (pick < 14) begin
        ts = rand_ts();
        send_beat(OP_HIT, rand_hit(ts));
        ev_ts = ts;
      end else if (pick < 38) begin
        ts = ev_ts + TS_W'(half) + 1'b1 + TS_W'($urandom_range(0, 63));
        send_beat(OP_HIT, rand_hit(ts));
        ev_ts = ts;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          ts = ev_ts - TS_W'($urandom_range(0, half));
        end else begin
          ts = ev_ts + TS_W'($urandom_range(0, half));
        end
        send_beat(OP_HIT, rand_hit(ts));
      end
    end
    wait_idle();
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each accepted record beat with the oldest expectation
  always @(posedge clk) begin : check_records
    rec_t want;
    if (!rst && rec_bus.valid && rec_bus.ready) begin
      records_seen++;
      if (rec_bus.last) events_seen++;
      if (expected_records.size() == 0) begin
        $error("record beat for slot %0d with no expectation pending", rec_bus.slot_channel);
        fail_count++;
      end else begin
        want = expected_records.pop_front();
        check_field("slot_channel", want.slot_channel, rec_bus.slot_channel);
        check_field("present", want.present, rec_bus.present);
        check_field("out_charge_short", want.charge_short, rec_bus.out_charge_short);
        check_field("out_charge_long", want.charge_long, rec_bus.out_charge_long);
        check_field("out_timestamp", want.timestamp, rec_bus.out_timestamp);
        check_field("out_fine_time", want.fine_time, rec_bus.out_fine_time);
        check_field("event_number", want.event_number, rec_bus.event_number);
        check_field("last", want.last, rec_bus.last);
      end
    end
  end

  // Record receiver: random stall bursts and a requested long hold-off
  initial begin : record_sink
    int burst;
    rec_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        rec_bus.ready <= 1'b0;
        while (rx_hold_cycles != 0) begin
          @(posedge clk);
          rx_hold_cycles--;
        end
        rec_bus.ready <= 1'b1;
      end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 4);
        rec_bus.ready <= 1'b0;
        repeat (burst) @(posedge clk);
        rec_bus.ready <= 1'b1;
      end else begin
        rec_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : run_tests
    hit_bus.valid <= 1'b0;
    hit_bus.operation <= OP_HIT;
    hit_bus.channel <= '0;
    hit_bus.charge_short <= '0;
    hit_bus.charge_long <= '0;
    hit_bus.timestamp <= '0;
    hit_bus.fine_time <= '0;
    window_we <= 1'b0;
    window_wdata <= '0;
    bld_clear_slots();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_window_edges();
    test_field_extremes();
    test_zero_window();
    test_backpressure();
    test_random_stream(28, 32'd1);
    test_random_stream(28, 32'd0);
    test_random_stream(28, $urandom_range(2, 5000));
    test_random_stream(18, '1);
    idle_enabled = 1'b0;
    test_random_stream(28, WINDOW_RESET);

    $display("Covered %0d hit and flush beats, %0d slot records in %0d events.",
             beats_sent, records_seen, events_seen);
    $display("Windows used: reset value, zero, one, maximum and random; long receiver hold-off.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
